### design/cru_pkg.sv
package cru_pkg;

   localparam int DIFF_W = 33;
   localparam int TOT_W  = 32;
   localparam int TCA_W  = 52;
   localparam int TM_W   = 51;
   localparam int DIST_W = 31;
   localparam int LEN_W  = 33;
   localparam int QUO_W  = 32;
   localparam int NUM_W  = LEN_W + QUO_W - 1;
   localparam int TM_LO_W = 25;
   localparam int TM_HI_W = TM_W - TM_LO_W;

   localparam logic OP_COLLIDE = 1'b1;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_RADIUS   = 2'd2;

   typedef struct packed {
      logic              is_col;
      logic              hit;
      logic              zero;
      logic              sx;
      logic              sy;
      logic [DIFF_W-1:0] vxm;
      logic [DIFF_W-1:0] vym;
      logic [TOT_W-1:0]  total;
      logic [TM_W-1:0]   tm;
      logic [LEN_W-1:0]  len;
      logic [DIST_W-1:0] entry_dist;
   } cru_ctx_type;

   function automatic logic [31:0] sat_s32(input logic [31:0] mag, input logic neg);
      logic [31:0] res;
      if (neg) begin
         res = mag[31] ? 32'h8000_0000 : (~mag + 32'd1);
      end else begin
         res = mag[31] ? 32'h7FFF_FFFF : mag;
      end
      return res;
   endfunction

endpackage

### design/circle_ray_and_collision_unit_top.sv
// The square root between an accepted request beat and its response beat has ROOT_W steps,
//   where ROOT_W = RAD_W / 2 is set by FRAC_BITS (52 steps at FRAC_BITS = 16).
// Throughput: one beat per cycle, held while the response is stalled; the square root
//   (one result bit per stage) and the 32-stage restoring divider set depth, not rate.
// Reset: synchronous, active high; clears all valid bits and the circle registers to zero.
module circle_ray_and_collision_unit_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [17:0] req_dir_x,
   input  logic signed [17:0] req_dir_y,
   input  logic        [30:0] req_player_radius,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic        [30:0] rsp_distance,
   output logic signed [31:0] rsp_push_x,
   output logic signed [31:0] rsp_push_y,
   input  logic               csr_wr_en,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_wdata
);
   import cru_pkg::*;

   localparam int RAD_NEED = (2 * FRAC_BITS + 67 > 103) ? 2 * FRAC_BITS + 67 : 103;
   localparam int RAD_W    = RAD_NEED + (RAD_NEED % 2);
   localparam int ROOT_W   = RAD_W / 2;

   logic signed [31:0] cx_ff, cy_ff;
   logic        [30:0] cr_ff;

   logic en;
   logic s1_load;

   logic                     s1_vld_ff, s1_op_ff;
   logic signed [DIFF_W-1:0] s1_tx_ff, s1_ty_ff, s1_tx_in, s1_ty_in;
   logic signed [17:0]       s1_dx_ff, s1_dy_ff;
   logic [TOT_W-1:0]         s1_total_ff;
   logic [30:0]              s1_r_ff;

   logic                     s2_vld_ff;
   cru_ctx_type              s2_ctx_ff, s2_ctx_in;
   logic [2*DIFF_W-1:0]      s2_sqx_ff, s2_sqy_ff;
   logic signed [TM_W-1:0]   s2_pdx_ff, s2_pdy_ff;
   logic [61:0]              s2_r2_ff;
   logic [2*TOT_W-1:0]       s2_tot2_ff;

   logic                     s3_vld_ff;
   cru_ctx_type              s3_ctx_ff;
   logic [2*DIFF_W-1:0]      s3_t2_ff;
   logic signed [TCA_W-1:0]  s3_tca_ff;
   logic [61:0]              s3_r2_ff;
   logic [2*TOT_W-1:0]       s3_tot2_ff;

   logic                     s4_vld_ff, s4_neg_ff;
   cru_ctx_type              s4_ctx_ff, s4_ctx_in;
   logic [2*TM_HI_W-1:0]     s4_hh_ff;
   logic [TM_W-1:0]          s4_hl_ff;
   logic [2*TM_LO_W-1:0]     s4_ll_ff;
   logic [2*DIFF_W-1:0]      s4_t2_ff;
   logic [61:0]              s4_r2_ff;

   logic                     s5_vld_ff, s5_neg_ff;
   cru_ctx_type              s5_ctx_ff;
   logic [RAD_W-1:0]         s5_sq_ff;
   logic [2*DIFF_W-1:0]      s5_t2_ff;
   logic [61:0]              s5_r2_ff;

   logic                     s6_vld_ff, s6_neg_ff;
   cru_ctx_type              s6_ctx_ff;
   logic [RAD_W-1:0]         s6_rhs_ff;
   logic [2*DIFF_W-1:0]      s6_t2_ff;

   logic [RAD_W-1:0]         t2s, rad_in;
   logic                     ray_ok;
   cru_ctx_type              sr_ctx_in;

   logic                     sr_vld_ff  [0:ROOT_W];
   cru_ctx_type              sr_ctx_ff  [0:ROOT_W];
   logic [RAD_W-1:0]         sr_rad_ff  [0:ROOT_W];
   logic [ROOT_W+1:0]        sr_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]        sr_root_ff [0:ROOT_W];

   logic                     pa_vld_ff;
   cru_ctx_type              pa_ctx_ff, pa_ctx_in;
   logic [TOT_W-1:0]         pa_ov_ff, pa_ov_in;
   logic [ROOT_W-1:0]        sq_root, sq_diff;
   logic                     sq_ge;

   logic [NUM_W-1:0]         nx_in, ny_in;

   logic                     dv_vld_ff  [0:QUO_W];
   cru_ctx_type              dv_ctx_ff  [0:QUO_W];
   logic [QUO_W-1:0]         dv_numx_ff [0:QUO_W];
   logic [QUO_W-1:0]         dv_numy_ff [0:QUO_W];
   logic [LEN_W-1:0]         dv_remx_ff [0:QUO_W];
   logic [LEN_W-1:0]         dv_remy_ff [0:QUO_W];
   logic [QUO_W-1:0]         dv_qx_ff   [0:QUO_W];
   logic [QUO_W-1:0]         dv_qy_ff   [0:QUO_W];

   logic                     rsp_valid_ff, rsp_hit_ff, rsp_hit_in;
   logic [DIST_W-1:0]        rsp_distance_ff, rsp_distance_in;
   logic [31:0]              rsp_push_x_ff, rsp_push_y_ff, rsp_push_x_in, rsp_push_y_in;
   cru_ctx_type              out_ctx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cr_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CENTER_X: cx_ff <= csr_wdata;
            CSR_CENTER_Y: cy_ff <= csr_wdata;
            CSR_RADIUS:   cr_ff <= csr_wdata[30:0];
            default:      ;
         endcase
      end
   end

   // hold the pipe while the response register is stalled; stage 1 still loads when empty
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = en || !s1_vld_ff;
   assign req_stall = !s1_load;

   always_comb begin
      if (req_operation == OP_COLLIDE) begin
         s1_tx_in = {req_point_x[31], req_point_x} - {cx_ff[31], cx_ff};
         s1_ty_in = {req_point_y[31], req_point_y} - {cy_ff[31], cy_ff};
      end else begin
         s1_tx_in = {cx_ff[31], cx_ff} - {req_point_x[31], req_point_x};
         s1_ty_in = {cy_ff[31], cy_ff} - {req_point_y[31], req_point_y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (s1_load) s1_vld_ff <= req_valid;
      if (s1_load) begin
         s1_op_ff    <= req_operation;
         s1_tx_ff    <= s1_tx_in;
         s1_ty_ff    <= s1_ty_in;
         s1_dx_ff    <= req_dir_x;
         s1_dy_ff    <= req_dir_y;
         s1_total_ff <= {1'b0, cr_ff} + {1'b0, req_player_radius};
         s1_r_ff     <= cr_ff;
      end
   end

   always_comb begin
      s2_ctx_in        = '0;
      s2_ctx_in.is_col = (s1_op_ff == OP_COLLIDE);
      s2_ctx_in.sx     = s1_tx_ff[DIFF_W-1];
      s2_ctx_in.sy     = s1_ty_ff[DIFF_W-1];
      s2_ctx_in.vxm    = s1_tx_ff[DIFF_W-1] ? (~s1_tx_ff + 1'b1) : s1_tx_ff;
      s2_ctx_in.vym    = s1_ty_ff[DIFF_W-1] ? (~s1_ty_ff + 1'b1) : s1_ty_ff;
      s2_ctx_in.total  = s1_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
      if (en) begin
         s2_ctx_ff  <= s2_ctx_in;
         s2_sqx_ff  <= s2_ctx_in.vxm * s2_ctx_in.vxm;
         s2_sqy_ff  <= s2_ctx_in.vym * s2_ctx_in.vym;
         s2_pdx_ff  <= s1_dx_ff * s1_tx_ff;
         s2_pdy_ff  <= s1_dy_ff * s1_ty_ff;
         s2_r2_ff   <= s1_r_ff * s1_r_ff;
         s2_tot2_ff <= s1_total_ff * s1_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= s2_vld_ff;
      if (en) begin
         s3_ctx_ff  <= s2_ctx_ff;
         s3_t2_ff   <= s2_sqx_ff + s2_sqy_ff;
         s3_tca_ff  <= {s2_pdx_ff[TM_W-1], s2_pdx_ff} + {s2_pdy_ff[TM_W-1], s2_pdy_ff};
         s3_r2_ff   <= s2_r2_ff;
         s3_tot2_ff <= s2_tot2_ff;
      end
   end

   always_comb begin
      s4_ctx_in      = s3_ctx_ff;
      s4_ctx_in.tm   = s3_tca_ff[TM_W-1:0];
      s4_ctx_in.zero = (s3_t2_ff == '0);
      s4_ctx_in.hit  = (s3_t2_ff < {2'b00, s3_tot2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (en) s4_vld_ff <= s3_vld_ff;
      if (en) begin
         s4_ctx_ff <= s4_ctx_in;
         s4_neg_ff <= s3_tca_ff[TCA_W-1];
         s4_hh_ff  <= s3_tca_ff[TM_W-1:TM_LO_W] * s3_tca_ff[TM_W-1:TM_LO_W];
         s4_hl_ff  <= s3_tca_ff[TM_W-1:TM_LO_W] * s3_tca_ff[TM_LO_W-1:0];
         s4_ll_ff  <= s3_tca_ff[TM_LO_W-1:0] * s3_tca_ff[TM_LO_W-1:0];
         s4_t2_ff  <= s3_t2_ff;
         s4_r2_ff  <= s3_r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (en) s5_vld_ff <= s4_vld_ff;
      if (en) begin
         s5_ctx_ff <= s4_ctx_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_sq_ff  <= (RAD_W'(s4_hh_ff) << (2 * TM_LO_W))
                    + (RAD_W'(s4_hl_ff) << (TM_LO_W + 1))
                    + RAD_W'(s4_ll_ff);
         s5_t2_ff  <= s4_t2_ff;
         s5_r2_ff  <= s4_r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (en) s6_vld_ff <= s5_vld_ff;
      if (en) begin
         s6_ctx_ff <= s5_ctx_ff;
         s6_neg_ff <= s5_neg_ff;
         s6_rhs_ff <= s5_sq_ff + (RAD_W'(s5_r2_ff) << (2 * FRAC_BITS));
         s6_t2_ff  <= s5_t2_ff;
      end
   end

   always_comb begin
      t2s       = RAD_W'(s6_t2_ff) << (2 * FRAC_BITS);
      ray_ok    = (s6_rhs_ff >= t2s) && !s6_neg_ff;
      sr_ctx_in = s6_ctx_ff;
      if (s6_ctx_ff.is_col) begin
         rad_in = RAD_W'(s6_t2_ff);
      end else begin
         sr_ctx_in.hit = ray_ok;
         rad_in        = ray_ok ? (s6_rhs_ff - t2s) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sr_vld_ff[0] <= 1'b0;
      else if (en) sr_vld_ff[0] <= s6_vld_ff;
      if (en) begin
         sr_ctx_ff[0]  <= sr_ctx_in;
         sr_rad_ff[0]  <= rad_in;
         sr_rem_ff[0]  <= '0;
         sr_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [ROOT_W+1:0] rem_in, trial;
      logic              ge;

      always_comb begin
         rem_in = {sr_rem_ff[k][ROOT_W-1:0], sr_rad_ff[k][RAD_W-1 -: 2]};
         trial  = {sr_root_ff[k], 2'b01};
         ge     = (rem_in >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) sr_vld_ff[k+1] <= 1'b0;
         else if (en) sr_vld_ff[k+1] <= sr_vld_ff[k];
         if (en) begin
            sr_ctx_ff[k+1]  <= sr_ctx_ff[k];
            sr_rad_ff[k+1]  <= {sr_rad_ff[k][RAD_W-3:0], 2'b00};
            sr_rem_ff[k+1]  <= ge ? (rem_in - trial) : rem_in;
            sr_root_ff[k+1] <= {sr_root_ff[k][ROOT_W-2:0], ge};
         end
      end
   end

   always_comb begin
      sq_root   = sr_root_ff[ROOT_W];
      sq_ge     = (ROOT_W'(sr_ctx_ff[ROOT_W].tm) >= sq_root);
      sq_diff   = ROOT_W'(sr_ctx_ff[ROOT_W].tm) - sq_root;
      pa_ctx_in = sr_ctx_ff[ROOT_W];
      pa_ctx_in.len = sq_root[LEN_W-1:0];
      pa_ov_in  = sr_ctx_ff[ROOT_W].total - sq_root[TOT_W-1:0];
      if (!sr_ctx_ff[ROOT_W].is_col) begin
         pa_ctx_in.hit = sr_ctx_ff[ROOT_W].hit && sq_ge;
         if (!pa_ctx_in.hit) begin
            pa_ctx_in.entry_dist = '0;
         end else if (|sq_diff[ROOT_W-1:FRAC_BITS+DIST_W]) begin
            pa_ctx_in.entry_dist = '1;
         end else begin
            pa_ctx_in.entry_dist = sq_diff[FRAC_BITS+DIST_W-1:FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pa_vld_ff <= 1'b0;
      else if (en) pa_vld_ff <= sr_vld_ff[ROOT_W];
      if (en) begin
         pa_ctx_ff <= pa_ctx_in;
         pa_ov_ff  <= pa_ov_in;
      end
   end

   assign nx_in = NUM_W'(pa_ctx_ff.vxm * pa_ov_ff);
   assign ny_in = NUM_W'(pa_ctx_ff.vym * pa_ov_ff);

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (en) dv_vld_ff[0] <= pa_vld_ff;
      if (en) begin
         dv_ctx_ff[0]  <= pa_ctx_ff;
         dv_remx_ff[0] <= {1'b0, nx_in[NUM_W-1:QUO_W]};
         dv_remy_ff[0] <= {1'b0, ny_in[NUM_W-1:QUO_W]};
         dv_numx_ff[0] <= nx_in[QUO_W-1:0];
         dv_numy_ff[0] <= ny_in[QUO_W-1:0];
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      logic [LEN_W:0] shx_in, shy_in;
      logic           gex, gey;

      always_comb begin
         shx_in = {dv_remx_ff[k], dv_numx_ff[k][QUO_W-1]};
         shy_in = {dv_remy_ff[k], dv_numy_ff[k][QUO_W-1]};
         gex    = (shx_in >= {1'b0, dv_ctx_ff[k].len});
         gey    = (shy_in >= {1'b0, dv_ctx_ff[k].len});
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[k+1] <= 1'b0;
         else if (en) dv_vld_ff[k+1] <= dv_vld_ff[k];
         if (en) begin
            dv_ctx_ff[k+1]  <= dv_ctx_ff[k];
            dv_numx_ff[k+1] <= {dv_numx_ff[k][QUO_W-2:0], 1'b0};
            dv_numy_ff[k+1] <= {dv_numy_ff[k][QUO_W-2:0], 1'b0};
            dv_remx_ff[k+1] <= gex ? LEN_W'(shx_in - {1'b0, dv_ctx_ff[k].len})
                                   : shx_in[LEN_W-1:0];
            dv_remy_ff[k+1] <= gey ? LEN_W'(shy_in - {1'b0, dv_ctx_ff[k].len})
                                   : shy_in[LEN_W-1:0];
            dv_qx_ff[k+1]   <= {dv_qx_ff[k][QUO_W-2:0], gex};
            dv_qy_ff[k+1]   <= {dv_qy_ff[k][QUO_W-2:0], gey};
         end
      end
   end

   always_comb begin
      out_ctx         = dv_ctx_ff[QUO_W];
      rsp_hit_in      = out_ctx.hit;
      rsp_distance_in = out_ctx.entry_dist;
      rsp_push_x_in   = '0;
      rsp_push_y_in   = '0;
      if (out_ctx.is_col && out_ctx.hit) begin
         if (out_ctx.zero) begin
            rsp_push_y_in = sat_s32(out_ctx.total, 1'b0);
         end else begin
            rsp_push_x_in = sat_s32(dv_qx_ff[QUO_W], out_ctx.sx);
            rsp_push_y_in = sat_s32(dv_qy_ff[QUO_W], out_ctx.sy);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= dv_vld_ff[QUO_W];
      if (en) begin
         rsp_hit_ff      <= rsp_hit_in;
         rsp_distance_ff <= rsp_distance_in;
         rsp_push_x_ff   <= rsp_push_x_in;
         rsp_push_y_ff   <= rsp_push_y_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_push_x   = rsp_push_x_ff;
   assign rsp_push_y   = rsp_push_y_ff;

`ifndef SYNTHESIS
   a_stall_only_when_frozen: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled while pipe can advance");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(s6_vld_ff) && $stable(dv_vld_ff[QUO_W]) && $stable(pa_vld_ff)))
      else $error("pipe moved while frozen");

   a_dist_is_ray_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_distance_ff != '0) |->
      (rsp_hit_ff && rsp_push_x_ff == '0 && rsp_push_y_ff == '0))
      else $error("nonzero distance on a non-ray beat");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_vld_ff[QUO_W] && dv_ctx_ff[QUO_W].is_col && dv_ctx_ff[QUO_W].hit
       && !dv_ctx_ff[QUO_W].zero) |->
      (dv_remx_ff[QUO_W] < dv_ctx_ff[QUO_W].len && dv_remy_ff[QUO_W] < dv_ctx_ff[QUO_W].len))
      else $error("divider remainder not below divisor");
`endif

endmodule
